>>> hw/rtl/lif_neuron_step_assert.svh
// Assertion helpers for the neuron step block.
// Both sample on clk and are disabled while rst_n is low.
`ifndef LIF_NEURON_STEP_ASSERT_SVH
`define LIF_NEURON_STEP_ASSERT_SVH

// Same-cycle implication
`define LIFN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LIFN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lifn_pkg.sv
package lifn_pkg;

  // History depth, also the largest usable refractory length
  localparam int MAX_REFRACTORY = 64;
  // Working width of the voltage sum before clamping
  localparam int SUM_W = 52;
  localparam int CFG_IDX_W = 3;

  // Register reset values, Q16.16
  localparam logic signed [31:0] REST_RST      = -32'sd4587520;
  localparam logic signed [31:0] RESET_RST     = -32'sd4587520;
  localparam logic signed [31:0] THRESHOLD_RST = -32'sd3604480;
  localparam logic signed [31:0] INITIAL_RST   = -32'sd4587520;
  localparam logic [15:0]        LEAK_GAIN_RST  = 16'd655;
  localparam logic [31:0]        INPUT_GAIN_RST = 32'd65536;
  localparam logic [31:0]        NOISE_GAIN_RST = 32'd0;

  // Voltage shown and stored on a spike (-20.0)
  localparam logic signed [31:0] SPIKE_MARK = -32'sd1310720;
  localparam logic signed [31:0] I32_MAX    = 32'sh7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REST       = 3'd0,
    CFG_RESET      = 3'd1,
    CFG_THRESHOLD  = 3'd2,
    CFG_INITIAL    = 3'd3,
    CFG_LEAK_GAIN  = 3'd4,
    CFG_INPUT_GAIN = 3'd5,
    CFG_NOISE_GAIN = 3'd6,
    CFG_REFRACTORY = 3'd7
  } cfg_idx_t;

  // Rounded input-side terms handed to the state update
  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] full_term;   // input current term plus noise term
    logic signed [SUM_W-1:0] noise_term;  // noise term alone
  } term_t;

endpackage

>>> hw/rtl/lifn_term.sv
module lifn_term
  import lifn_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               s0_valid,
  input  logic signed [32:0] s0_sum,
  input  logic signed [15:0] s0_noise,
  input  logic [31:0]        input_gain,
  input  logic [31:0]        noise_gain,
  output term_t              term
);

  logic               s1_valid_r;
  logic signed [65:0] in_prod_r;
  logic signed [48:0] nz_prod_r;
  logic signed [65:0] in_rnd;
  logic signed [48:0] nz_rnd;
  logic signed [SUM_W-1:0] in_term;
  logic signed [SUM_W-1:0] nz_term;
  term_t              term_r;
  term_t              term_nxt;

  // Multiply stage: raw signed products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_prod_r <= s0_sum * $signed({1'b0, input_gain});
      nz_prod_r <= s0_noise * $signed({1'b0, noise_gain});
    end
  end

  // Round half away from zero: bias by half, one less when negative, then shift
  always_comb begin
    in_rnd  = in_prod_r + (in_prod_r[65] ? 66'sd32767 : 66'sd32768);
    nz_rnd  = nz_prod_r + (nz_prod_r[48] ? 49'sd2047 : 49'sd2048);
    in_term = SUM_W'(in_rnd >>> 16);
    nz_term = SUM_W'(nz_rnd >>> 12);
    term_nxt.valid      = s1_valid_r;
    term_nxt.full_term  = in_term + nz_term;
    term_nxt.noise_term = nz_term;
  end

  // Term stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r <= '0;
    end else if (adv) begin
      term_r <= term_nxt;
    end
  end

  assign term = term_r;

endmodule

>>> hw/rtl/lif_neuron_step.sv
// Leaky integrate-and-fire neuron, one time step per request, Q16.16 with
// saturation. The block takes one step every cycle unless the result side
// stalls: a four-register pipeline (input, product, rounded term, result)
// moves as a whole whenever the result register is empty or being taken, so
// in_ready follows out_ready. The membrane voltage and spike history close
// their loop in the last stage, where the leak multiply, the voltage sum and
// the clamp and threshold compares are combinational. The configuration port
// is always ready; the user must write registers only while no step is in
// flight (the block does not enforce this); writing initial_voltage also loads the membrane.
module lif_neuron_step
  import lifn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_ext_current,
  input  logic signed [31:0]   in_syn_current,
  input  logic signed [15:0]   in_noise_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_new_voltage,
  output logic                 out_spike,
  output logic                 out_refractory,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  `include "lif_neuron_step_assert.svh"

  // Configuration
  logic signed [31:0]        rest_r;
  logic signed [31:0]        reset_v_r;
  logic signed [31:0]        thresh_r;
  logic [15:0]               leak_gain_r;
  logic [31:0]               input_gain_r;
  logic [31:0]               noise_gain_r;
  logic [MAX_REFRACTORY-1:0] refr_mask_r;
  logic                      refr_on_r;
  logic [MAX_REFRACTORY-1:0] refr_mask_nxt;
  logic                      cfg_we;

  // Pipeline
  logic               adv;
  logic               s0_valid_r;
  logic signed [32:0] s0_sum_r;
  logic signed [15:0] s0_noise_r;
  term_t              term;

  // Neuron state and result
  logic signed [31:0]        mem_r;
  logic [MAX_REFRACTORY-1:0] hist_r;
  logic                      out_valid_r;
  logic signed [31:0]        out_volt_r;
  logic                      out_spike_r;
  logic                      out_refr_r;

  logic                      in_window;
  logic                      refr;
  logic                      full;
  logic signed [31:0]        v;
  logic signed [32:0]        diff;
  logic signed [49:0]        leak_prod;
  logic signed [49:0]        leak_rnd;
  logic signed [SUM_W-1:0]   leak_term;
  logic signed [SUM_W-1:0]   sum;
  logic signed [31:0]        clamped;
  logic                      spike_nxt;
  logic signed [31:0]        volt_nxt;
  logic                      upd;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign upd       = adv && term.valid;

  // Window mask: history bits 1 .. R-1; lengths above the depth act as the depth
  always_comb begin
    for (int k = 0; k < MAX_REFRACTORY; k++) begin
      refr_mask_nxt[k] = (k != 0) && (k < int'(cfg_wdata[6:0]));
    end
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r       <= REST_RST;
      reset_v_r    <= RESET_RST;
      thresh_r     <= THRESHOLD_RST;
      leak_gain_r  <= LEAK_GAIN_RST;
      input_gain_r <= INPUT_GAIN_RST;
      noise_gain_r <= NOISE_GAIN_RST;
      refr_mask_r  <= '0;
      refr_on_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REST:       rest_r       <= cfg_wdata;
        CFG_RESET:      reset_v_r    <= cfg_wdata;
        CFG_THRESHOLD:  thresh_r     <= cfg_wdata;
        CFG_INITIAL:    ;
        CFG_LEAK_GAIN:  leak_gain_r  <= cfg_wdata[15:0];
        CFG_INPUT_GAIN: input_gain_r <= cfg_wdata;
        CFG_NOISE_GAIN: noise_gain_r <= cfg_wdata;
        CFG_REFRACTORY: begin
          refr_mask_r <= refr_mask_nxt;
          refr_on_r   <= cfg_wdata[6:0] != 7'd0;
        end
      endcase
    end
  end

  // Input stage: hold the request, pre-add the two currents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sum_r   <= {in_ext_current[31], in_ext_current}
                  + {in_syn_current[31], in_syn_current};
      s0_noise_r <= in_noise_sample;
    end
  end

  lifn_term u_term (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .s0_valid   (s0_valid_r),
    .s0_sum     (s0_sum_r),
    .s0_noise   (s0_noise_r),
    .input_gain (input_gain_r),
    .noise_gain (noise_gain_r),
    .term       (term)
  );

  // Step update: pick start voltage, leak, add terms, clamp, threshold
  always_comb begin
    in_window = |(hist_r & refr_mask_r);
    if (in_window) begin
      v    = mem_r;
      refr = 1'b1;
      full = 1'b0;
    end else if (hist_r[0]) begin
      v    = reset_v_r;
      refr = refr_on_r;
      full = !refr_on_r;
    end else begin
      v    = mem_r;
      refr = 1'b0;
      full = 1'b1;
    end

    diff      = {rest_r[31], rest_r} - {v[31], v};
    leak_prod = diff * $signed({1'b0, leak_gain_r});
    leak_rnd  = leak_prod + (leak_prod[49] ? 50'sd32767 : 50'sd32768);
    leak_term = SUM_W'(leak_rnd >>> 16);
    sum       = SUM_W'(v) + leak_term + (full ? term.full_term : term.noise_term);

    if (sum < SUM_W'(rest_r)) begin
      clamped = rest_r;
    end else if (sum > SUM_W'(I32_MAX)) begin
      clamped = I32_MAX;
    end else begin
      clamped = sum[31:0];
    end

    spike_nxt = full && (clamped > thresh_r);
    volt_nxt  = spike_nxt ? SPIKE_MARK : clamped;
  end

  // State: membrane voltage and spike history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_r  <= INITIAL_RST;
      hist_r <= '0;
    end else if (cfg_we && cfg_idx_t'(cfg_index) == CFG_INITIAL) begin
      mem_r <= cfg_wdata;
    end else if (upd) begin
      mem_r  <= volt_nxt;
      hist_r <= {hist_r[MAX_REFRACTORY-2:0], spike_nxt};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= term.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_volt_r  <= volt_nxt;
      out_spike_r <= spike_nxt;
      out_refr_r  <= refr;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_voltage = out_volt_r;
  assign out_spike       = out_spike_r;
  assign out_refractory  = out_refr_r;

  `LIFN_ASSERT_IMP(a_spike_not_refr, out_valid_r && out_spike_r, !out_refr_r, "spike on refractory step")
  `LIFN_ASSERT_IMP(a_spike_mark, out_valid_r && out_spike_r, out_volt_r == SPIKE_MARK, "spike without marker")
  `LIFN_ASSERT_IMP(a_above_rest, out_valid_r && !out_spike_r, out_volt_r >= rest_r, "voltage below rest")
  `LIFN_ASSERT_NXT(a_hist_push, upd && spike_nxt, hist_r[0] && mem_r == SPIKE_MARK, "spike not recorded")
  `LIFN_ASSERT_IMP(a_stall_holds_in, out_valid_r && !out_ready, !in_ready, "request taken while stalled")

endmodule

>>> sim/lif_neuron_step_test.sv
`timescale 1ns / 1ps

module lif_neuron_step_test;
  import lifn_pkg::*;

  localparam int ONE_Q16     = 65536;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic signed [31:0] voltage;
    logic               spike;
    logic               refractory;
  } step_out_t;

  typedef struct {
    logic               is_reg;
    cfg_idx_t           idx;
    logic [31:0]        data;
    logic signed [31:0] ext;
    logic signed [31:0] syn;
    logic signed [15:0] nz;
    logic               pinned;
    step_out_t          want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [31:0]   in_ext_current;
  logic signed [31:0]   in_syn_current;
  logic signed [15:0]   in_noise_sample;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [31:0]   out_new_voltage;
  logic                 out_spike;
  logic                 out_refractory;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  // Fixed expectation for the request currently offered
  logic      pin_en;
  step_out_t pin_val;

  // Neuron model state and register copy
  logic signed [31:0]        rest_v, reset_v, thresh_v, init_v;
  logic [15:0]               leak_g;
  logic [31:0]               input_g, noise_g;
  logic [6:0]                refr_len;
  logic signed [31:0]        membrane;
  logic [MAX_REFRACTORY-1:0] history;

  step_out_t expected_steps[$];
  plan_row_t plan[$];

  int  mismatches = 0;
  int  steps_checked = 0;
  int  spikes_seen = 0;
  int  refr_seen = 0;
  int  reg_writes = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  lif_neuron_step i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ext_current  (in_ext_current),
    .in_syn_current  (in_syn_current),
    .in_noise_sample (in_noise_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_voltage (out_new_voltage),
    .out_spike       (out_spike),
    .out_refractory  (out_refractory),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Signed value times unsigned gain over 2^sh, rounded half away from zero
  function automatic logic signed [79:0] gain_round(input logic signed [79:0] a,
                                                    input logic [79:0] b,
                                                    input int unsigned sh);
    logic [79:0] mag;
    logic [79:0] r;
    mag = a[79] ? -a : a;
    r = (mag * b + (80'd1 << (sh - 1))) >> sh;
    return a[79] ? -$signed(r) : $signed(r);
  endfunction

  function automatic void clear_neuron();
    rest_v   = REST_RST;
    reset_v  = RESET_RST;
    thresh_v = THRESHOLD_RST;
    init_v   = INITIAL_RST;
    leak_g   = LEAK_GAIN_RST;
    input_g  = INPUT_GAIN_RST;
    noise_g  = NOISE_GAIN_RST;
    refr_len = '0;
    membrane = INITIAL_RST;
    history  = '0;
  endfunction

  function automatic void load_reg(input cfg_idx_t idx, input logic [31:0] d);
    case (idx)
      CFG_REST:       rest_v = d;
      CFG_RESET:      reset_v = d;
      CFG_THRESHOLD:  thresh_v = d;
      CFG_INITIAL: begin
        init_v = d;
        membrane = d;
      end
      CFG_LEAK_GAIN:  leak_g = d[15:0];
      CFG_INPUT_GAIN: input_g = d;
      CFG_NOISE_GAIN: noise_g = d;
      CFG_REFRACTORY: refr_len = d[6:0];
      default: ;
    endcase
  endfunction

  // Advance the neuron by one time step and return the expected output
  function automatic step_out_t neuron_step(input logic signed [31:0] ext,
                                            input logic signed [31:0] syn,
                                            input logic signed [15:0] nz);
    int unsigned        lim;
    logic               in_win, refr, full, spk;
    logic signed [79:0] v, nv, cur, rest_w, thresh_w;
    step_out_t          res;
    lim = (refr_len > MAX_REFRACTORY) ? MAX_REFRACTORY : refr_len;
    in_win = 1'b0;
    for (int k = 1; k < lim; k++)
      if (history[k]) in_win = 1'b1;
    rest_w = rest_v;
    thresh_w = thresh_v;
    if (in_win) begin
      v = membrane;
      refr = 1'b1;
      full = 1'b0;
    end else if (history[0]) begin
      v = reset_v;
      refr = (lim > 0);
      full = !refr;
    end else begin
      v = membrane;
      refr = 1'b0;
      full = 1'b1;
    end
    nv = v + gain_round(rest_w - v, leak_g, 16) + gain_round(nz, noise_g, 12);
    if (full) begin
      cur = ext;
      cur = cur + syn;
      nv = nv + gain_round(cur, input_g, 16);
    end
    if (nv < rest_w) nv = rest_w;
    if (nv > I32_MAX) nv = I32_MAX;
    spk = 1'b0;
    if (full && nv > thresh_w) begin
      spk = 1'b1;
      nv = SPIKE_MARK;
    end
    membrane = nv[31:0];
    history = {history[MAX_REFRACTORY-2:0], spk};
    res.voltage = nv[31:0];
    res.spike = spk;
    res.refractory = refr;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at result %0d, %s: got %h, want %h", steps_checked, what, got, want);
    mismatches++;
  endtask

  // Track register writes and requests, check every result
  always @(posedge clk) begin
    step_out_t want;
    if (!rst_n) begin
      clear_neuron();
    end else begin
      if (cfg_valid && cfg_ready) begin
        load_reg(cfg_idx_t'(cfg_index), cfg_wdata);
        reg_writes++;
      end
      if (in_valid && in_ready) begin
        want = neuron_step(in_ext_current, in_syn_current, in_noise_sample);
        if (pin_en) want = pin_val;
        expected_steps.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_steps.size() == 0) begin
          report_mismatch("result with nothing expected", out_new_voltage, '0);
        end else begin
          want = expected_steps.pop_front();
          if (out_new_voltage !== want.voltage)
            report_mismatch("new_voltage", out_new_voltage, want.voltage);
          if (out_spike !== want.spike)
            report_mismatch("spike", {31'd0, out_spike}, {31'd0, want.spike});
          if (out_refractory !== want.refractory)
            report_mismatch("refractory", {31'd0, out_refractory}, {31'd0, want.refractory});
          if (out_spike === 1'b1) spikes_seen++;
          if (out_refractory === 1'b1) refr_seen++;
        end
        steps_checked++;
      end
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random back-pressure, a long hold on request
  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic offer_step(input logic signed [31:0] ext, input logic signed [31:0] syn,
                            input logic signed [15:0] nz, input logic pin,
                            input step_out_t want);
    in_valid <= 1'b1;
    in_ext_current <= ext;
    in_syn_current <= syn;
    in_noise_sample <= nz;
    pin_en <= pin;
    pin_val <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_gap();
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold requests until every expected result is back, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_steps.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_step(input logic signed [31:0] ext,
                                   input logic signed [31:0] syn,
                                   input logic signed [15:0] nz);
    plan_row_t row;
    row = '{1'b0, CFG_REST, 32'd0, ext, syn, nz, 1'b0, '0};
    plan.push_back(row);
  endfunction

  function automatic void add_pinned(input logic signed [31:0] ext,
                                     input logic signed [31:0] syn,
                                     input logic signed [15:0] nz,
                                     input logic signed [31:0] v,
                                     input logic s, input logic r);
    plan_row_t row;
    row = '{1'b0, CFG_REST, 32'd0, ext, syn, nz, 1'b1, '{v, s, r}};
    plan.push_back(row);
  endfunction

  function automatic void add_reg(input cfg_idx_t idx, input logic [31:0] d);
    plan_row_t row;
    row = '{1'b1, idx, d, 32'sd0, 32'sd0, 16'sd0, 1'b0, '0};
    plan.push_back(row);
  endfunction

  // Random register setup: plausible biology mostly, raw bit patterns when wild
  task automatic program_regs(input bit wild, input bit every);
    int unsigned        refr_choices[10] = '{0, 1, 2, 3, 5, 10, 63, 64, 65, 127};
    logic signed [31:0] rest_pick;
    logic [31:0]        vals[8];
    rest_pick = -4587520 + int'($urandom_range(0, 1310720)) - 655360;
    if (wild) begin
      vals = '{$urandom, $urandom, $urandom, $urandom, $urandom_range(0, 65535),
               $urandom, $urandom, $urandom_range(0, 127)};
    end else begin
      vals[CFG_REST]       = rest_pick;
      vals[CFG_RESET]      = rest_pick + int'($urandom_range(0, 655360));
      vals[CFG_THRESHOLD]  = rest_pick + int'($urandom_range(ONE_Q16, 20 * ONE_Q16));
      vals[CFG_INITIAL]    = rest_pick + int'($urandom_range(0, 20 * ONE_Q16));
      vals[CFG_LEAK_GAIN]  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 8192);
      vals[CFG_INPUT_GAIN] = $urandom_range(0, 2 * ONE_Q16);
      vals[CFG_NOISE_GAIN] = $urandom_range(0, 2 * ONE_Q16);
      vals[CFG_REFRACTORY] = refr_choices[$urandom_range(0, 9)];
    end
    wait_drained();
    for (int i = 0; i < 8; i++)
      if (every || $urandom_range(0, 1) == 1)
        write_reg(cfg_idx_t'(i), vals[i]);
  endtask

  // Stimulus
  initial begin
    logic signed [31:0] ext, syn;
    logic signed [15:0] nz;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_ext_current <= '0;
    in_syn_current <= '0;
    in_noise_sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_REST;
    cfg_wdata <= '0;
    pin_en <= 1'b0;
    pin_val <= '0;

    // At reset values: rest, a saturating spike, restart from reset with no refractory time
    add_pinned(32'sd0, 32'sd0, 16'sd0, REST_RST, 1'b0, 1'b0);
    add_pinned(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF, SPIKE_MARK, 1'b1, 1'b0);
    add_pinned(32'sh8000_0000, 32'sh8000_0000, 16'sh8000, REST_RST, 1'b0, 1'b0);
    add_step(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd0);
    // Spike, then the step after it and the refractory window
    add_reg(CFG_REFRACTORY, 32'd3);
    add_reg(CFG_NOISE_GAIN, ONE_Q16);
    add_step(20 * ONE_Q16, 32'sd0, 16'sh1000);
    add_step(20 * ONE_Q16, 32'sd0, 16'sd0);
    add_step(20 * ONE_Q16, 32'sd0, 16'sd0);
    add_step(20 * ONE_Q16, 32'sd0, 16'sd0);
    add_step(20 * ONE_Q16, 32'sd0, 16'sd0);
    // Oversized refractory length, preset membrane through initial_voltage
    add_reg(CFG_REFRACTORY, 32'd127);
    add_reg(CFG_INITIAL, -60 * ONE_Q16);
    add_step(32'sd0, 32'sd0, 16'sh7FFF);
    add_step(40 * ONE_Q16, 32'sh7FFF_FFFF, 16'sh8000);
    add_step(32'sd0, 32'sd0, 16'sd0);
    // Register extremes: saturate high, clamp at the lowest rest
    add_reg(CFG_REST, 32'h8000_0000);
    add_reg(CFG_RESET, 32'h7FFF_FFFF);
    add_reg(CFG_THRESHOLD, 32'h7FFF_FFFF);
    add_reg(CFG_LEAK_GAIN, 32'h0000_FFFF);
    add_reg(CFG_INPUT_GAIN, 32'hFFFF_FFFF);
    add_reg(CFG_NOISE_GAIN, 32'hFFFF_FFFF);
    add_reg(CFG_REFRACTORY, 32'd0);
    add_reg(CFG_INITIAL, 32'h7FFF_FFFF);
    add_pinned(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF, I32_MAX, 1'b0, 1'b0);
    add_pinned(32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 32'sh8000_0000, 1'b0, 1'b0);
    add_reg(CFG_THRESHOLD, 32'h8000_0000);
    add_step(32'sd0, 32'sd0, 16'sd0);
    add_step(32'sd1, 32'sd0, 16'sd0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        wait_drained();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        offer_step(plan[i].ext, plan[i].syn, plan[i].nz, plan[i].pinned, plan[i].want);
        sender_gap();
      end
    end

    // Random phases, each under a fresh register setup
    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p == 0 || p == 3);
      program_regs(p == 7 || p == 8, p == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 20) hold_req = 1'b1;
        if (p == 5 && n == 50) wait_drained();
        if ($urandom_range(0, 99) < 15) begin
          ext = $urandom;
          syn = $urandom;
        end else begin
          ext = int'($urandom_range(0, 32 * ONE_Q16)) - 16 * ONE_Q16;
          syn = int'($urandom_range(0, 4 * ONE_Q16)) - 2 * ONE_Q16;
        end
        if ($urandom_range(0, 99) < 30) nz = 16'($urandom);
        else nz = 16'(int'($urandom_range(0, 8192)) - 4096);
        offer_step(ext, syn, nz, 1'b0, '0);
        sender_gap();
      end
    end

    wait_drained();
    $display("Covered %0d neuron steps with %0d spikes and %0d refractory steps,",
             steps_checked, spikes_seen, refr_seen);
    $display("across %0d register writes and %0d random setups.", reg_writes, NUM_PHASES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still expected", expected_steps.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
